>>> rtl/rid_pkg.sv
package rid_pkg;

   // Field widths of one item
   localparam int VALUE_W = 32;
   localparam int BASE_W  = 6;
   localparam int MIN_W   = 8;
   localparam int CAP_W   = 7;
   localparam int CHAR_W  = 7;
   localparam int TLEN_W  = 7;

   // Radix limits
   localparam logic [BASE_W-1:0] BASE_LOW  = 6'd2;
   localparam logic [BASE_W-1:0] BASE_HIGH = 6'd36;

   // Character mapping
   localparam logic [CHAR_W-1:0] ASCII_ZERO   = 7'h30;
   localparam logic [CHAR_W-1:0] LOWER_OFFSET = 7'd39;
   localparam logic [CHAR_W-1:0] UPPER_OFFSET = 7'd7;
   localparam logic [BASE_W-1:0] LAST_DECIMAL = 6'd9;

   // Command to the serial divider
   typedef struct packed {
      logic               start;
      logic [VALUE_W-1:0] dividend;
      logic [BASE_W-1:0]  divisor;
   } div_cmd_type;

   // Status and result of the serial divider
   typedef struct packed {
      logic               busy;
      logic               done;
      logic [VALUE_W-1:0] quotient;
      logic [BASE_W-1:0]  remainder;
   } div_stat_type;

   // Saturate a radix into the legal range
   function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] base);
      logic [BASE_W-1:0] res;
      res = base;
      if (base < BASE_LOW) begin
         res = BASE_LOW;
      end else if (base > BASE_HIGH) begin
         res = BASE_HIGH;
      end
      return res;
   endfunction

   // Map a digit value to its ASCII character
   function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] digit,
                                                    input logic              lower);
      logic [CHAR_W-1:0] res;
      res = ASCII_ZERO + CHAR_W'(digit);
      if (digit > LAST_DECIMAL) begin
         res = res + (lower ? LOWER_OFFSET : UPPER_OFFSET);
      end
      return res;
   endfunction

endpackage

>>> rtl/rid_ram.sv
module rid_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/rid_divider.sv
module rid_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  rid_pkg::div_cmd_type cmd,
   output rid_pkg::div_stat_type stat
);

   import rid_pkg::*;

   localparam int CNT_W = $clog2(VALUE_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(VALUE_W - 1);

   logic [VALUE_W-1:0] quo_ff, quo_in;
   logic [BASE_W-1:0]  rem_ff, rem_in;
   logic [BASE_W-1:0]  dvs_ff, dvs_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   logic [BASE_W:0]    trial;
   logic [BASE_W:0]    diff;
   logic               fits;

   // One quotient bit per cycle: shift the dividend out, the quotient bit in
   assign trial = {rem_ff, quo_ff[VALUE_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         quo_in  = cmd.dividend;
         rem_in  = '0;
         dvs_in  = cmd.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[VALUE_W-2:0], fits};
         rem_in = fits ? diff[BASE_W-1:0] : trial[BASE_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy      = busy_ff;
   assign stat.done      = done_ff;
   assign stat.quotient  = quo_ff;
   assign stat.remainder = rem_ff;

endmodule

>>> rtl/radix_integer_to_digits_unit.sv
// Each digit of the value comes from the serial divider, one quotient bit per
// cycle, and is written to the digit store on the hand-off; the string is then
// sized, and each character is read from the registered digit store and loaded
// into the output register, which stalls while the result side holds it off.
// Reset (synchronous, active high) clears control state; the digit store
// is not cleared and needs no clearing pass.
module radix_integer_to_digits_unit #(
   parameter int MAX_CHARS = 64
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: number_value[31:0], number_base[37:32], lower_letters[38],
   //            min_digit_count[46:39], buffer_capacity[53:47], zero[55:54]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,
   // rsp_tdata: out_char[6:0], total_length[13:7], zero[15:14]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   output logic        rsp_tlast
);

   import rid_pkg::*;

   localparam int AW    = $clog2(MAX_CHARS);
   localparam int LEN_W = $clog2(MAX_CHARS + 1);
   localparam int CW    = (LEN_W > CAP_W) ? LEN_W : CAP_W;
   localparam logic [CW-1:0] MAX_C = CW'(MAX_CHARS);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DIVIDE = 5'b00010,
      ST_LENGTH = 5'b00100,
      ST_FETCH  = 5'b01000,
      ST_LOAD   = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [BASE_W-1:0]  radix_ff, radix_in;
   logic               lower_ff, lower_in;
   logic [MIN_W-1:0]   min_ff, min_in;
   logic [CAP_W-1:0]   cap_ff, cap_in;
   logic [LEN_W-1:0]   ndig_ff, ndig_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic               pad_ff, pad_in;
   logic               out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]  out_char_ff, out_char_in;
   logic               out_last_ff, out_last_in;
   logic [TLEN_W-1:0]  out_len_ff, out_len_in;

   div_cmd_type        dv_cmd;
   div_stat_type       dv_stat;
   logic               accept;
   logic               more_digits;
   logic               load;
   logic               ram_we;
   logic               ram_re;
   logic [BASE_W-1:0]  ram_rd_data;
   logic [BASE_W-1:0]  digit;

   logic               min_pos;
   logic [CW-1:0]      min_v;
   logic [CW-1:0]      cap_v;
   logic [CW-1:0]      ndig_v;
   logic [CW-1:0]      target;
   logic [CW-1:0]      len_v;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // Keep dividing while a quotient is left and the digit store has room
   assign more_digits = (dv_stat.quotient != '0) && ((CW'(ndig_ff) + 1'b1) < MAX_C);
   assign ram_we      = (state_ff == ST_DIVIDE) && dv_stat.done;
   assign ram_re      = (state_ff == ST_FETCH);

   // Start the divider on a new item or on the quotient of the last step
   always_comb begin
      dv_cmd.start    = accept || (ram_we && more_digits);
      dv_cmd.dividend = accept ? req_tdata[VALUE_W-1:0] : dv_stat.quotient;
      dv_cmd.divisor  = accept ? clamp_base(req_tdata[37:32]) : radix_ff;
   end

   rid_divider u_divider (
      .clock (clock),
      .reset (reset),
      .cmd   (dv_cmd),
      .stat  (dv_stat)
   );

   rid_ram #(
      .WIDTH (BASE_W),
      .DEPTH (MAX_CHARS)
   ) u_digit_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ndig_ff[AW-1:0]),
      .wr_data (dv_stat.remainder),
      .rd_en   (ram_re),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   // Size the string: pad to the minimum, bounded by capacity and store depth
   always_comb begin
      min_pos = !min_ff[MIN_W-1] && (min_ff[MIN_W-2:0] != '0);
      min_v   = CW'(min_ff[MIN_W-2:0]);
      cap_v   = CW'(cap_ff);
      ndig_v  = CW'(ndig_ff);
      target  = (min_v < cap_v) ? min_v : cap_v;
      if (target > MAX_C) begin
         target = MAX_C;
      end
      len_v = ndig_v;
      if (min_pos && (min_v > ndig_v) && (target > ndig_v)) begin
         len_v = target;
      end
   end

   // Padding positions read as zero digits
   assign digit = pad_ff ? '0 : ram_rd_data;
   assign load  = (state_ff == ST_LOAD) && (!out_valid_ff || rsp_tready);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      radix_in = radix_ff;
      lower_in = lower_ff;
      min_in   = min_ff;
      cap_in   = cap_ff;
      ndig_in  = ndig_ff;
      len_in   = len_ff;
      idx_in   = idx_ff;
      pad_in   = pad_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               radix_in = clamp_base(req_tdata[37:32]);
               lower_in = req_tdata[38];
               min_in   = req_tdata[46:39];
               cap_in   = req_tdata[53:47];
               ndig_in  = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (dv_stat.done) begin
               ndig_in = ndig_ff + 1'b1;
               if (!more_digits) begin
                  state_in = ST_LENGTH;
               end
            end
         end
         ST_LENGTH: begin
            len_in   = LEN_W'(len_v);
            idx_in   = AW'(len_v - 1'b1);
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            pad_in   = (CW'(idx_ff) >= CW'(ndig_ff));
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (load) begin
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff - 1'b1;
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: hold until taken, refill on load
   always_comb begin
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_len_in   = out_len_ff;
      if (load) begin
         out_valid_in = 1'b1;
         out_char_in  = digit_char(digit, lower_ff);
         out_last_in  = (idx_ff == '0);
         out_len_in   = TLEN_W'(len_ff);
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         ndig_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         ndig_ff      <= ndig_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      radix_ff    <= radix_in;
      lower_ff    <= lower_in;
      min_ff      <= min_in;
      cap_ff      <= cap_in;
      len_ff      <= len_in;
      idx_ff      <= idx_in;
      pad_ff      <= pad_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
      out_len_ff  <= out_len_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {2'b00, out_len_ff, out_char_ff};

   // A divider result only arrives while digits are being collected
   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      dv_stat.done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside the divide phase");

   // The string never ends up shorter than its digits
   a_len_covers_digits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |-> (CW'(len_ff) >= CW'(ndig_ff)))
      else $error("string length below digit count");

   // Every character leaving the block reports a nonzero length
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[13:7] != '0))
      else $error("character with zero total length");

   // Loading the last character returns the sequencer to idle and flags it as last
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (load && (idx_ff == '0)) |=> (state_ff == ST_IDLE) && rsp_tlast)
      else $error("last character without return to idle");

endmodule

>>> test/tb.sv
module tb;

   // Character mapping and string limit of the converter, and test sizes
   localparam logic [6:0] CH_ZERO    = 7'h30;
   localparam logic [6:0] LOWER_SKIP = 7'd39;
   localparam logic [6:0] UPPER_SKIP = 7'd7;
   localparam int         MAX_DIGITS = 64;
   localparam int         DIR_ROWS   = 21;
   localparam int         RAND_ITEMS = 330;
   localparam int         PAUSE_AT   = 150;
   localparam int         HOLD_AT    = 120;
   localparam int         HOLD_LEN   = 400;

   // One expected character of a converted string
   typedef struct packed {
      logic [6:0] ch;
      logic       last;
      logic [6:0] len;
   } char_result_type;

   // One directed conversion; an empty string means use the predictor
   typedef struct {
      logic [31:0]       value;
      logic [5:0]        base;
      logic              lower;
      logic signed [7:0] min_cnt;
      logic [6:0]        cap;
      string             text;
   } conv_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // req_tdata: number_value, number_base, lower_letters, min_digit_count,
   //            buffer_capacity, zero pad (lowest bit up)
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // rsp_tdata: out_char, total_length, zero pad (lowest bit up)
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;

   char_result_type pending_chars[$];
   conv_row_type    dir_rows[DIR_ROWS];
   int              mismatches = 0;
   int              chars_seen = 0;

   radix_integer_to_digits_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Abort a hung run
   initial begin
      #30000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Offer one conversion, then queue the characters it must produce
   task automatic send_conversion(input logic [31:0] v, input logic [5:0] b,
                                  input logic lo, input logic signed [7:0] m,
                                  input logic [6:0] c, input string text,
                                  input int gap);
      logic [31:0]     radix;
      logic [31:0]     rest;
      logic [5:0]      digit_buf [MAX_DIGITS];
      logic [5:0]      d;
      int              len;
      int              target;
      int              mi;
      char_result_type r;
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, c, m, lo, b, v};
      do @(posedge clock); while (!req_tready);

      // Typed-in expectation
      if (text.len() != 0) begin
         for (int k = 0; k < text.len(); k++) begin
            r.ch   = 7'(text[k]);
            r.last = (k == text.len() - 1);
            r.len  = 7'(text.len());
            pending_chars.push_back(r);
         end
         return;
      end

      // Saturate the radix, then divide out the digits, least significant first
      radix = (b < 6'd2) ? 32'd2 : (b > 6'd36) ? 32'd36 : 32'(b);
      rest  = v;
      len   = 0;
      do begin
         digit_buf[len] = 6'(rest % radix);
         rest = rest / radix;
         len++;
      end while (rest != 0 && len < MAX_DIGITS);

      // Pad with zeros up to the minimum, bounded by capacity and string limit
      mi = int'(m);
      if (mi > 0 && mi > len) begin
         target = mi;
         if (target > int'(c)) target = int'(c);
         if (target > MAX_DIGITS) target = MAX_DIGITS;
         while (len < target) begin
            digit_buf[len] = '0;
            len++;
         end
      end

      // Emit most significant first
      for (int k = 0; k < len; k++) begin
         d    = digit_buf[len - 1 - k];
         r.ch = CH_ZERO + 7'(d);
         if (d > 6'd9) r.ch = r.ch + (lo ? LOWER_SKIP : UPPER_SKIP);
         r.last = (k == len - 1);
         r.len  = 7'(len);
         pending_chars.push_back(r);
      end
   endtask

   // Result side: random stalls, one long hold-off, compare against the queue
   initial begin : rsp_side
      int              stall;
      char_result_type want;
      wait (!reset);
      forever begin
         if (chars_seen == HOLD_AT) begin
            repeat (HOLD_LEN) begin
               @(negedge clock);
               rsp_tready <= 1'b0;
            end
         end
         stall = ((chars_seen / 60) % 3 == 1) ? 0 : $urandom_range(0, 5);
         repeat (stall) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         chars_seen++;
         if (pending_chars.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected item, expected none, got char %h len %0d last %b",
                     $time, rsp_tdata[6:0], rsp_tdata[13:7], rsp_tlast);
         end else begin
            want = pending_chars.pop_front();
            if (rsp_tdata[6:0] !== want.ch) begin
               mismatches++;
               $display("%0t: out_char expected %h got %h",
                        $time, want.ch, rsp_tdata[6:0]);
            end
            if (rsp_tlast !== want.last) begin
               mismatches++;
               $display("%0t: last_char expected %b got %b",
                        $time, want.last, rsp_tlast);
            end
            if (rsp_tdata[13:7] !== want.len) begin
               mismatches++;
               $display("%0t: total_length expected %0d got %0d",
                        $time, want.len, rsp_tdata[13:7]);
            end
         end
      end
   end

   // Stimulus: directed table, then random conversions, then drain
   initial begin : req_side
      logic [31:0]       v;
      logic [5:0]        b;
      logic              lo;
      logic signed [7:0] m;
      logic [6:0]        c;
      int                gap;

      // Extremes, radix saturation, padding limits, value zero
      dir_rows[0]  = '{32'd0, 6'd10, 1'b0, -8'sd1, 7'd64, "0"};
      dir_rows[1]  = '{32'hFFFFFFFF, 6'd16, 1'b0, -8'sd1, 7'd64, "FFFFFFFF"};
      dir_rows[2]  = '{32'hFFFFFFFF, 6'd16, 1'b1, -8'sd1, 7'd64, "ffffffff"};
      dir_rows[3]  = '{32'hFFFFFFFF, 6'd2, 1'b0, -8'sd1, 7'd64,
                       "11111111111111111111111111111111"};
      dir_rows[4]  = '{32'd35, 6'd36, 1'b0, -8'sd1, 7'd64, "Z"};
      dir_rows[5]  = '{32'd35, 6'd63, 1'b1, -8'sd1, 7'd64, "z"};
      dir_rows[6]  = '{32'd5, 6'd0, 1'b0, -8'sd1, 7'd64, "101"};
      dir_rows[7]  = '{32'd2, 6'd1, 1'b0, -8'sd1, 7'd64, "10"};
      dir_rows[8]  = '{32'd36, 6'd37, 1'b0, -8'sd1, 7'd64, "10"};
      dir_rows[9]  = '{32'd7, 6'd10, 1'b0, -8'sd128, 7'd127, "7"};
      dir_rows[10] = '{32'd42, 6'd10, 1'b0, 8'sd5, 7'd64, "00042"};
      dir_rows[11] = '{32'd42, 6'd10, 1'b0, 8'sd10, 7'd4, "0042"};
      dir_rows[12] = '{32'd42, 6'd10, 1'b0, 8'sd10, 7'd0, "42"};
      dir_rows[13] = '{32'd42, 6'd10, 1'b1, 8'sd2, 7'd64, "42"};
      dir_rows[14] = '{32'd2147483647, 6'd10, 1'b0, 8'sd0, 7'd64, "2147483647"};
      dir_rows[15] = '{32'd1, 6'd2, 1'b0, 8'sd1, 7'd1, "1"};
      dir_rows[16] = '{32'd0, 6'd10, 1'b0, 8'sd127, 7'd127, ""};
      dir_rows[17] = '{32'hFFFFFFFF, 6'd2, 1'b0, 8'sd64, 7'd64, ""};
      dir_rows[18] = '{32'hFFFFFFFF, 6'd2, 1'b1, 8'sd40, 7'd1, ""};
      dir_rows[19] = '{32'h80000000, 6'd36, 1'b1, 8'sd0, 7'd127, ""};
      dir_rows[20] = '{32'hDEADBEEF, 6'd36, 1'b1, 8'sd127, 7'd127, ""};

      // Hold reset, then release it on a falling edge
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         send_conversion(dir_rows[i].value, dir_rows[i].base, dir_rows[i].lower,
                         dir_rows[i].min_cnt, dir_rows[i].cap, dir_rows[i].text,
                         $urandom_range(0, 5));
      end

      for (int i = 0; i < RAND_ITEMS; i++) begin
         // Drop the offer and hold off until every queued character has come out
         if (i == PAUSE_AT) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            while (pending_chars.size() != 0) @(posedge clock);
         end
         case ($urandom_range(0, 3))
            0: v = $urandom();
            1: v = $urandom_range(0, 255);
            2: v = $urandom_range(0, 1) ? 32'hFFFFFFFF : 32'd0;
            default: v = $urandom() >> $urandom_range(0, 31);
         endcase
         b  = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                          : 6'($urandom_range(2, 36));
         lo = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 9))
            0, 1: m = 8'($urandom_range(0, 255));
            2: m = -8'sd1;
            default: m = 8'($urandom_range(0, 40));
         endcase
         c   = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                           : 7'($urandom_range(1, 64));
         gap = ((i / 40) % 3 == 1) ? 0 : $urandom_range(0, 5);
         send_conversion(v, b, lo, m, c, "", gap);
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      // Drain, then watch for stray characters
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
